// ----- rtl/trf_pkg.sv -----
// ---------------------------------------------------------------------------
// Rail fence transposer package
// Shared constants, controller state type and the command and status words
// that pass between the controller and the datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package trf_pkg;

    localparam int MAX_LEN_DEF   = 64;
    localparam int MAX_RAILS_DEF = 16;

    localparam int DEPTH_W   = 5;
    localparam int SYMBOL_W  = 8;
    localparam int PDATA_W   = 32;
    localparam int PADDR_W   = 3;

    localparam logic [DEPTH_W-1:0] RAIL_DEPTH_RST = 5'd2;

    // register index, taken from paddr[2]
    localparam logic REG_RAIL_DEPTH = 1'b0;

    localparam logic ACTION_ENCRYPT = 1'b0;
    localparam logic ACTION_DECRYPT = 1'b1;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PERM,
        ST_DRAIN,
        ST_READ,
        ST_SHOW
    } trf_state_t;

    typedef struct packed {
        logic load;
        logic perm_start;
        logic perm_step;
        logic rd_issue;
        logic out_next;
    } trf_cmd_t;

    typedef struct packed {
        logic perm_last;
        logic out_last;
    } trf_status_t;

endpackage

`default_nettype wire

// ----- rtl/trf_if.sv -----
// ---------------------------------------------------------------------------
// Rail fence transposer channels
// Valid/ready channels for message words in and permuted words out.
// ---------------------------------------------------------------------------
`default_nettype none

interface trf_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] symbol;
    logic       last_in;

    modport source (output valid, output action, output symbol, output last_in,
                    input ready);
    modport sink   (input valid, input action, input symbol, input last_in,
                    output ready);
endinterface

interface trf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_symbol;
    logic       last_out;
    logic       truncated;

    modport source (output valid, output out_symbol, output last_out,
                    output truncated, input ready);
    modport sink   (input valid, input out_symbol, input last_out,
                    input truncated, output ready);
endinterface

`default_nettype wire

// ----- rtl/rail_fence_transposer_unit.sv -----
// ---------------------------------------------------------------------------
// Rail fence transposer
// Buffers a byte message and emits it permuted by the zigzag rail pattern.
// ---------------------------------------------------------------------------
// Each accepted word is written to the message store. When the word marked
// last arrives, the block walks the zigzag order once, one byte per cycle,
// moving the message into a permuted copy, then emits the words one at a
// time: a read of the permuted copy into the output register, then a
// hand-off once the sink is ready; the next read waits for that hand-off.
// No new word is accepted until the last result is taken.
// Bytes beyond MAX_LEN are dropped and flagged on every result. rail_depth
// at byte address 0 selects the rail count; 0 and 1 both pass the message
// through unchanged, values above MAX_RAILS act as MAX_RAILS.
// ---------------------------------------------------------------------------
`default_nettype none

module rail_fence_transposer_unit
    import trf_pkg::*;
#(
    parameter int MAX_LEN   = MAX_LEN_DEF,
    parameter int MAX_RAILS = MAX_RAILS_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    trf_in_if.sink                  msg,
    trf_out_if.source               result,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0]      prdata,
    output logic                    pready
);

    logic [DEPTH_W-1:0] rail_depth_reg;
    logic               reg_sel;
    trf_cmd_t           cmd;
    trf_status_t        status;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == REG_RAIL_DEPTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rail_depth_reg <= RAIL_DEPTH_RST;
        end
        else if (psel && penable && pwrite && reg_sel)
        begin
            rail_depth_reg <= pwdata[DEPTH_W-1:0];
        end
    end

    assign prdata = reg_sel ? PDATA_W'(rail_depth_reg) : '0;

    trf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (msg.valid),
        .in_last   (msg.last_in),
        .in_ready  (msg.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    trf_datapath #(
        .MAX_LEN   (MAX_LEN),
        .MAX_RAILS (MAX_RAILS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .rail_depth (rail_depth_reg),
        .action     (msg.action),
        .symbol     (msg.symbol),
        .out_symbol (result.out_symbol),
        .last_out   (result.last_out),
        .truncated  (result.truncated),
        .status     (status)
    );

endmodule

`default_nettype wire

// ----- rtl/trf_ctrl.sv -----
// ---------------------------------------------------------------------------
// Rail fence transposer controller
// Sequences message load, the permutation pass and word-by-word emission.
// ---------------------------------------------------------------------------
`default_nettype none

module trf_ctrl
    import trf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_last,
    output logic             in_ready,
    output logic             out_valid,
    input  wire logic        out_ready,
    input  wire trf_status_t status,
    output trf_cmd_t         cmd
);

    trf_state_t state_reg;
    trf_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (in_last)
                    begin
                        cmd.perm_start = 1'b1;
                        state_next     = ST_PERM;
                    end
                end
            end
            ST_PERM:
            begin
                cmd.perm_step = 1'b1;
                if (status.perm_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_READ;
            end
            ST_READ:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_SHOW;
            end
            ST_SHOW:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.out_next = 1'b1;
                    state_next   = status.out_last ? ST_LOAD : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/trf_datapath.sv -----
// ---------------------------------------------------------------------------
// Rail fence transposer datapath
// Message store, zigzag order generator, permuted copy and output register.
// ---------------------------------------------------------------------------
`default_nettype none

module trf_datapath
    import trf_pkg::*;
#(
    parameter int MAX_LEN   = MAX_LEN_DEF,
    parameter int MAX_RAILS = MAX_RAILS_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire trf_cmd_t            cmd,
    input  wire logic [DEPTH_W-1:0]  rail_depth,
    input  wire logic                action,
    input  wire logic [SYMBOL_W-1:0] symbol,
    output logic [SYMBOL_W-1:0]      out_symbol,
    output logic                     last_out,
    output logic                     truncated,
    output trf_status_t              status
);

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int RW = $clog2(MAX_RAILS + 1);
    localparam int PW = $clog2(MAX_LEN + 2 * MAX_RAILS + 1);

    logic [SYMBOL_W-1:0] store_mem [MAX_LEN];
    logic [SYMBOL_W-1:0] perm_mem  [MAX_LEN];

    logic [LW-1:0]       len_reg;
    logic                ovf_reg;
    logic                action_reg;
    logic [LW-1:0]       k_reg;
    logic [LW-1:0]       p_reg;
    logic [RW-1:0]       rail_reg;
    logic [PW-1:0]       pos_reg;
    logic                phase_reg;
    logic                wr_valid_reg;
    logic [AW-1:0]       wr_addr_reg;
    logic [SYMBOL_W-1:0] store_rdata_reg;
    logic [SYMBOL_W-1:0] perm_rdata_reg;

    logic [RW-1:0]       depth;
    logic [PW-1:0]       step_a;
    logic [PW-1:0]       step_b;
    logic [PW-1:0]       step_sel;
    logic [PW-1:0]       step_alt;
    logic [PW-1:0]       step;
    logic [PW-1:0]       pos_sum;
    logic                rail_end;
    logic [AW-1:0]       rd_src;
    logic [AW-1:0]       wr_dst;

    // clamp depth to 1..MAX_RAILS
    always_comb
    begin
        if (rail_depth == '0)
        begin
            depth = RW'(1);
        end
        else if (32'(rail_depth) > 32'(MAX_RAILS))
        begin
            depth = RW'(MAX_RAILS);
        end
        else
        begin
            depth = RW'(rail_depth);
        end
    end

    // zigzag walk: steps alternate 2*(depth-1-rail) and 2*rail
    always_comb
    begin
        step_a   = PW'(depth - rail_reg - RW'(1)) << 1;
        step_b   = PW'(rail_reg) << 1;
        step_sel = phase_reg ? step_b : step_a;
        step_alt = phase_reg ? step_a : step_b;
        if (step_sel != '0)
        begin
            step = step_sel;
        end
        else if (step_alt != '0)
        begin
            step = step_alt;
        end
        else
        begin
            step = PW'(1);
        end
        pos_sum  = pos_reg + step;
        rail_end = (pos_sum >= PW'(len_reg));
    end

    always_comb
    begin
        if (action_reg == ACTION_ENCRYPT)
        begin
            rd_src = pos_reg[AW-1:0];
            wr_dst = k_reg[AW-1:0];
        end
        else
        begin
            rd_src = k_reg[AW-1:0];
            wr_dst = pos_reg[AW-1:0];
        end
    end

    assign status.perm_last = ((k_reg + LW'(1)) == len_reg);
    assign status.out_last  = ((p_reg + LW'(1)) == len_reg);

    assign out_symbol = perm_rdata_reg;
    assign last_out   = status.out_last;
    assign truncated  = ovf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg      <= '0;
            ovf_reg      <= 1'b0;
            action_reg   <= ACTION_ENCRYPT;
            k_reg        <= '0;
            p_reg        <= '0;
            rail_reg     <= '0;
            pos_reg      <= '0;
            phase_reg    <= 1'b0;
            wr_valid_reg <= 1'b0;
        end
        else
        begin
            wr_valid_reg <= cmd.perm_step;
            if (cmd.load)
            begin
                if (len_reg < LW'(MAX_LEN))
                begin
                    len_reg <= len_reg + LW'(1);
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end
            if (cmd.perm_start)
            begin
                action_reg <= action;
                k_reg      <= '0;
                p_reg      <= '0;
                rail_reg   <= '0;
                pos_reg    <= '0;
                phase_reg  <= 1'b0;
            end
            if (cmd.perm_step)
            begin
                k_reg <= k_reg + LW'(1);
                if (rail_end)
                begin
                    rail_reg  <= rail_reg + RW'(1);
                    pos_reg   <= PW'(rail_reg) + PW'(1);
                    phase_reg <= 1'b0;
                end
                else
                begin
                    pos_reg   <= pos_sum;
                    phase_reg <= ~phase_reg;
                end
            end
            if (cmd.out_next)
            begin
                p_reg <= p_reg + LW'(1);
                if (status.out_last)
                begin
                    len_reg <= '0;
                    ovf_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.perm_step)
        begin
            wr_addr_reg <= wr_dst;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && (len_reg < LW'(MAX_LEN)))
        begin
            store_mem[len_reg[AW-1:0]] <= symbol;
        end
        if (cmd.perm_step)
        begin
            store_rdata_reg <= store_mem[rd_src];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_valid_reg)
        begin
            perm_mem[wr_addr_reg] <= store_rdata_reg;
        end
        if (cmd.rd_issue)
        begin
            perm_rdata_reg <= perm_mem[p_reg[AW-1:0]];
        end
    end

endmodule

`default_nettype wire

// ----- tb/rail_fence_transposer_unit_tb.sv -----
// ---------------------------------------------------------------------------
// Rail fence transposer testbench
// Sends byte messages over the input channel and predicts each permuted
// message in a scoreboard, which checks every output word in order. The
// rail depth is changed over APB between messages and read back. Both
// channels idle at random, and one long output stall backs up the input.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

typedef struct {
    logic [7:0] sym;
    logic       last;
    logic       trunc;
} transposed_word_t;

class zigzag_scoreboard;
    logic [7:0]       message_bytes[$];
    bit               overflow;
    logic [4:0]       depth;
    transposed_word_t pending_words[$];
    int               fails;
    int               words_in;
    int               words_out;
    int               messages;
    int               clipped;

    function new();
        depth     = trf_pkg::RAIL_DEPTH_RST;
        overflow  = 1'b0;
        fails     = 0;
        words_in  = 0;
        words_out = 0;
        messages  = 0;
        clipped   = 0;
    endfunction

    function void set_depth(logic [4:0] value);
        depth = value;
    endfunction

    function int rail_of(int pos, int rails);
        int period;
        int m;
        if (rails <= 1)
            return 0;
        period = 2 * (rails - 1);
        m = pos % period;
        return (m < rails) ? m : period - m;
    endfunction

    function void note_word(logic act, logic [7:0] sym, logic last);
        int               rails;
        int               len;
        int               r;
        int               i;
        int               k;
        int               order[$];
        logic [7:0]       perm[];
        transposed_word_t w;
        words_in++;
        if (message_bytes.size() < trf_pkg::MAX_LEN_DEF)
            message_bytes.push_back(sym);
        else
            overflow = 1'b1;
        if (last !== 1'b1)
            return;
        rails = int'(depth);
        if (rails < 1)
            rails = 1;
        if (rails > trf_pkg::MAX_RAILS_DEF)
            rails = trf_pkg::MAX_RAILS_DEF;
        len = message_bytes.size();
        for (r = 0; r < rails; r++)
            for (i = 0; i < len; i++)
                if (rail_of(i, rails) == r)
                    order.push_back(i);
        perm = new[len];
        for (k = 0; k < len; k++)
        begin
            if (act == trf_pkg::ACTION_ENCRYPT)
                perm[k] = message_bytes[order[k]];
            else
                perm[order[k]] = message_bytes[k];
        end
        for (k = 0; k < len; k++)
        begin
            w.sym   = perm[k];
            w.last  = (k == len - 1);
            w.trunc = overflow;
            pending_words.push_back(w);
        end
        messages++;
        if (overflow)
            clipped++;
        message_bytes.delete();
        overflow = 1'b0;
    endfunction

    function void check_word(logic [7:0] sym, logic last, logic trunc);
        transposed_word_t w;
        words_out++;
        if (pending_words.size() == 0)
        begin
            fails++;
            $display("%0t: unexpected word: expected none, actual %02h last %b truncated %b",
                     $time, sym, last, trunc);
            return;
        end
        w = pending_words.pop_front();
        if (sym !== w.sym)
        begin
            fails++;
            $display("%0t: out_symbol mismatch: expected %02h, actual %02h",
                     $time, w.sym, sym);
        end
        if (last !== w.last)
        begin
            fails++;
            $display("%0t: last_out mismatch: expected %b, actual %b", $time, w.last, last);
        end
        if (trunc !== w.trunc)
        begin
            fails++;
            $display("%0t: truncated mismatch: expected %b, actual %b",
                     $time, w.trunc, trunc);
        end
    endfunction
endclass

module rail_fence_transposer_unit_tb;
    import trf_pkg::*;

    localparam logic [PADDR_W-1:0] DEPTH_ADDR = {REG_RAIL_DEPTH, 2'b00};
    localparam int LONG_HOLD   = 300;
    localparam int IDLE_SETTLE = 8;
    localparam int ITEM_TARGET = 300;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    trf_in_if  msg_ch ();
    trf_out_if res_ch ();

    zigzag_scoreboard sb = new();

    bit tx_calm;
    bit rx_calm;
    int hold_asked;
    int hold_served;
    int stall_left;
    int depth_writes;

    rail_fence_transposer_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .msg     (msg_ch),
        .result  (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    task automatic send_word(input logic act, input logic [7:0] sym, input logic last);
        int gap;
        msg_ch.valid   = 1'b1;
        msg_ch.action  = act;
        msg_ch.symbol  = sym;
        msg_ch.last_in = last;
        @(posedge clk);
        while (msg_ch.ready !== 1'b1)
            @(posedge clk);
        sb.note_word(act, sym, last);
        @(negedge clk);
        gap = tx_calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            msg_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic send_message(input int len, input logic act);
        int i;
        for (i = 0; i < len - 1; i++)
            send_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b0);
        send_word(act, 8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic wait_idle();
        msg_ch.valid = 1'b0;
        while (sb.pending_words.size() != 0)
            @(negedge clk);
        repeat (IDLE_SETTLE) @(negedge clk);
    endtask

    task automatic set_rail_depth(input logic [4:0] value);
        wait_idle();
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = DEPTH_ADDR;
        pwdata  = ($urandom() & ~32'h1F) | 32'(value);
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        sb.set_depth(value);
        depth_writes++;
        @(negedge clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        if (prdata[4:0] !== value)
        begin
            sb.fails++;
            $display("%0t: rail_depth readback mismatch: expected %0d, actual %0d",
                     $time, value, prdata[4:0]);
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // output sink: random stalls plus one long hold on request
    initial
    begin
        res_ch.ready = 1'b0;
        stall_left   = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_asked != hold_served)
            begin
                hold_served++;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                res_ch.ready = 1'b0;
                stall_left--;
            end
            else
            begin
                res_ch.ready = 1'b1;
                if (!rx_calm)
                    stall_left = pick_gap();
            end
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
                sb.check_word(res_ch.out_symbol, res_ch.last_out, res_ch.truncated);
        end
    end

    initial
    begin
        int         iter;
        int         len;
        int         pick;
        bit         hold_done;
        logic [4:0] d;
        logic [4:0] extremes[5];

        extremes       = '{5'd0, 5'd1, 5'd16, 5'd17, 5'd31};
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        msg_ch.valid   = 1'b0;
        msg_ch.action  = 1'b0;
        msg_ch.symbol  = '0;
        msg_ch.last_in = 1'b0;
        tx_calm        = 1'b0;
        rx_calm        = 1'b0;
        hold_asked     = 0;
        hold_served    = 0;
        depth_writes   = 0;
        hold_done      = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: reset depth, symbol extremes, both directions
        send_word(ACTION_DECRYPT, 8'h00, 1'b0);
        send_word(ACTION_DECRYPT, 8'hFF, 1'b0);
        send_word(ACTION_ENCRYPT, 8'h5A, 1'b1);
        send_message(3, ACTION_DECRYPT);
        set_rail_depth(5'd1);
        send_message(1, ACTION_ENCRYPT);
        send_message(4, ACTION_DECRYPT);
        set_rail_depth(5'd0);
        send_message(3, ACTION_ENCRYPT);
        set_rail_depth(5'd16);
        send_message(5, ACTION_DECRYPT);
        set_rail_depth(5'd31);
        send_message(6, ACTION_ENCRYPT);

        // random messages
        iter = 0;
        while (sb.words_in < ITEM_TARGET)
        begin
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            if (!hold_done && sb.words_in >= 120)
            begin
                hold_done = 1'b1;
                hold_asked++;
                send_message($urandom_range(10, 24), 1'($urandom_range(0, 1)));
                send_message($urandom_range(10, 24), 1'($urandom_range(0, 1)));
            end
            else
            begin
                if ($urandom_range(0, 2) == 0)
                begin
                    if ($urandom_range(0, 3) == 0)
                        d = extremes[$urandom_range(0, 4)];
                    else
                        d = 5'($urandom_range(0, 31));
                    set_rail_depth(d);
                end
                pick = $urandom_range(0, 99);
                if (iter == 0)
                    len = 64;
                else if (iter == 1)
                    len = 67;
                else if (pick < 80)
                    len = $urandom_range(1, 16);
                else if (pick < 92)
                    len = $urandom_range(17, 63);
                else
                    len = $urandom_range(64, 70);
                send_message(len, 1'($urandom_range(0, 1)));
            end
            iter++;
        end

        wait_idle();
        repeat (20) @(negedge clk);
        $display("Covered %0d messages (%0d truncated), %0d rail depth writes",
                 sb.messages, sb.clipped, depth_writes);
        $display("Words in %0d, words out %0d, both directions, depths 0 to 31",
                 sb.words_in, sb.words_out);
        if (sb.fails == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/trf_pkg.sv
rtl/trf_if.sv
rtl/trf_ctrl.sv
rtl/trf_datapath.sv
rtl/rail_fence_transposer_unit.sv
tb/rail_fence_transposer_unit_tb.sv
